// ----- src/imu_ca_pkg.sv -----
`default_nettype none
package imu_ca_pkg;

    localparam int CORDIC_STEPS_DEF = 20;
    localparam int SAT_W            = 52;

    // register indexes of the configuration port
    localparam logic [2:0] REG_MODE          = 3'd0;
    localparam logic [2:0] REG_RATE_GAIN     = 3'd1;
    localparam logic [2:0] REG_YAW_RATE_GAIN = 3'd2;
    localparam logic [2:0] REG_GYRO_WEIGHT   = 3'd3;
    localparam logic [2:0] REG_YAW_DEADBAND  = 3'd4;

    // operating modes
    localparam logic [1:0] MODE_GYRO  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_FUSE  = 2'd2;

    // angle axis select
    localparam logic [1:0] AXIS_PITCH = 2'd0;
    localparam logic [1:0] AXIS_ROLL  = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;

    localparam logic [1:0]  MODE_RST          = MODE_FUSE;
    localparam logic [31:0] RATE_GAIN_RST     = 32'd2618883;
    localparam logic [31:0] YAW_RATE_GAIN_RST = 32'd3767515;
    localparam logic [16:0] GYRO_WEIGHT_RST   = 17'd62415;
    localparam logic [16:0] WEIGHT_ONE        = 17'd65536;
    localparam logic [30:0] YAW_DEADBAND_RST  = 31'd6554;

    typedef struct packed {
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } imu_ca_in_t;

    typedef struct packed {
        logic signed [31:0] pitch_deg;
        logic signed [31:0] roll_deg;
        logic signed [31:0] yaw_deg;
    } imu_ca_out_t;

    typedef struct packed {
        logic       load;
        logic       gyro_en;
        logic [1:0] axis;
        logic       crd_start;
        logic       crd_latch;
        logic       crd_sel;
        logic       blend_en;
        logic       commit;
    } imu_ca_cmd_t;

    typedef struct packed {
        logic crd_done;
        logic out_hold;
    } imu_ca_stat_t;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:  r = 32'sd2949120;
            5'd1:  r = 32'sd1740967;
            5'd2:  r = 32'sd919879;
            5'd3:  r = 32'sd466945;
            5'd4:  r = 32'sd234379;
            5'd5:  r = 32'sd117304;
            5'd6:  r = 32'sd58666;
            5'd7:  r = 32'sd29335;
            5'd8:  r = 32'sd14668;
            5'd9:  r = 32'sd7334;
            5'd10: r = 32'sd3667;
            5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;
            5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;
            5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;
            5'd17: r = 32'sd29;
            5'd18: r = 32'sd14;
            5'd19: r = 32'sd7;
            5'd20: r = 32'sd4;
            5'd21: r = 32'sd2;
            5'd22: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_W'(64'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -SAT_W'(64'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/imu_ca_cordic.sv -----
`default_nettype none
module imu_ca_cordic #(
    parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  wire  signed [15:0] yin,
    input  wire  signed [15:0] xin,
    output logic               done,
    output logic signed [31:0] angle
);
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int VW    = 36;

    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0]   z_reg, z_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;

    logic signed [VW-1:0] xs, ys, xi, yi;
    logic signed [31:0]   ang;

    assign xi = VW'(xin) <<< 16;
    assign yi = VW'(yin) <<< 16;
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign ang = imu_ca_pkg::atan_entry(5'(cnt_reg));

    // pre-rotate on start, then one micro-rotation a cycle
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (start) begin
            zero_next = (xin == 16'sd0) && (yin == 16'sd0);
            cnt_next  = '0;
            busy_next = 1'b1;
            if (xin < 0) begin
                if (yin >= 0) begin
                    x_next = yi;
                    y_next = -xi;
                    z_next = 32'sd5898240;
                end else begin
                    x_next = -yi;
                    y_next = xi;
                    z_next = -32'sd5898240;
                end
            end else begin
                x_next = xi;
                y_next = yi;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
    end

    assign done  = done_reg;
    assign angle = zero_reg ? 32'sd0 : z_reg;
endmodule
`default_nettype wire

// ----- src/imu_ca_datapath.sv -----
`default_nettype none
module imu_ca_datapath #(
    parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_wr_en,
    input  wire  [2:0]              cfg_index,
    input  wire  [31:0]             cfg_wdata,
    input  imu_ca_pkg::imu_ca_in_t  in_data,
    input  imu_ca_pkg::imu_ca_cmd_t cmd,
    output imu_ca_pkg::imu_ca_stat_t stat,
    output imu_ca_pkg::imu_ca_out_t out_data,
    output logic                    out_valid,
    input  wire                     out_ready
);
    localparam int SW = imu_ca_pkg::SAT_W;

    logic [1:0]  mode_reg;
    logic [31:0] rate_gain_reg, yaw_rate_gain_reg;
    logic [16:0] gyro_weight_reg;
    logic [30:0] yaw_deadband_reg;

    imu_ca_pkg::imu_ca_in_t  in_reg;
    imu_ca_pkg::imu_ca_out_t out_reg, out_next;
    logic signed [31:0] pitch_reg, roll_reg, yaw_reg, prev_yaw_reg;
    logic signed [31:0] pg_reg, rg_reg, yg_reg, pa_reg, ra_reg, bp_reg, br_reg;
    logic signed [31:0] yaw_new, prev_new;
    logic               valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= imu_ca_pkg::MODE_RST;
            rate_gain_reg     <= imu_ca_pkg::RATE_GAIN_RST;
            yaw_rate_gain_reg <= imu_ca_pkg::YAW_RATE_GAIN_RST;
            gyro_weight_reg   <= imu_ca_pkg::GYRO_WEIGHT_RST;
            yaw_deadband_reg  <= imu_ca_pkg::YAW_DEADBAND_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                imu_ca_pkg::REG_MODE:          mode_reg          <= cfg_wdata[1:0];
                imu_ca_pkg::REG_RATE_GAIN:     rate_gain_reg     <= cfg_wdata;
                imu_ca_pkg::REG_YAW_RATE_GAIN: yaw_rate_gain_reg <= cfg_wdata;
                imu_ca_pkg::REG_GYRO_WEIGHT:   gyro_weight_reg   <= cfg_wdata[16:0];
                imu_ca_pkg::REG_YAW_DEADBAND:  yaw_deadband_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // gyro integration, one axis a cycle
    logic signed [15:0] g_sel;
    logic        [31:0] gain_sel;
    logic signed [31:0] old_sel;
    logic signed [48:0] g_prod;
    logic signed [32:0] g_delta;
    logic signed [SW-1:0] g_sum;

    always_comb begin
        case (cmd.axis)
            imu_ca_pkg::AXIS_PITCH: begin
                g_sel = in_reg.gyro_y; old_sel = pitch_reg;
            end
            imu_ca_pkg::AXIS_ROLL: begin
                g_sel = in_reg.gyro_x; old_sel = roll_reg;
            end
            default: begin
                g_sel = in_reg.gyro_z; old_sel = yaw_reg;
            end
        endcase
        gain_sel = (cmd.axis == imu_ca_pkg::AXIS_YAW && mode_reg == imu_ca_pkg::MODE_FUSE)
                   ? yaw_rate_gain_reg : rate_gain_reg;
        g_prod  = 49'(g_sel) * $signed({17'd0, gain_sel});
        g_delta = 33'((g_prod + 49'sd32768) >>> 16);
        if (cmd.axis == imu_ca_pkg::AXIS_PITCH) begin
            g_sum = SW'(old_sel) - SW'(g_delta);
        end else begin
            g_sum = SW'(old_sel) + SW'(g_delta);
        end
    end

    // blend: a*2^16 + w*(g - a), rounded half up
    logic        [16:0]   w_sat;
    logic signed [31:0]   bg, ba;
    logic signed [32:0]   b_diff;
    logic signed [SW-1:0] b_sum;

    always_comb begin
        w_sat  = (gyro_weight_reg > imu_ca_pkg::WEIGHT_ONE) ? imu_ca_pkg::WEIGHT_ONE
                                                             : gyro_weight_reg;
        bg     = (cmd.axis == imu_ca_pkg::AXIS_PITCH) ? pg_reg : rg_reg;
        ba     = (cmd.axis == imu_ca_pkg::AXIS_PITCH) ? pa_reg : ra_reg;
        b_diff = 33'(bg) - 33'(ba);
        b_sum  = (SW'(ba) <<< 16) + SW'(b_diff) * SW'($signed({1'b0, w_sat}))
                 + SW'(32768);
        b_sum  = b_sum >>> 16;
    end

    // shared atan2 unit
    logic               crd_done;
    logic signed [31:0] crd_angle;

    imu_ca_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.crd_start),
        .yin     (cmd.crd_sel ? in_reg.acc_y : in_reg.acc_x),
        .xin     (in_reg.acc_z),
        .done    (crd_done),
        .angle   (crd_angle)
    );

    // yaw deadband and final selection
    logic signed [32:0] yd;
    logic        [32:0] yd_abs;

    always_comb begin
        yd       = 33'(yg_reg) - 33'(prev_yaw_reg);
        yd_abs   = yd[32] ? 33'(-yd) : 33'(yd);
        yaw_new  = (yd_abs > {2'b00, yaw_deadband_reg}) ? yg_reg : prev_yaw_reg;
        prev_new = prev_yaw_reg;
        out_next = {pitch_reg, roll_reg, yaw_reg};
        case (mode_reg)
            imu_ca_pkg::MODE_GYRO:  out_next = {pg_reg, rg_reg, yg_reg};
            imu_ca_pkg::MODE_ACCEL: out_next = {pa_reg, ra_reg, 32'sd0};
            imu_ca_pkg::MODE_FUSE: begin
                out_next = {bp_reg, br_reg, yaw_new};
                prev_new = yaw_new;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg    <= '0;
            roll_reg     <= '0;
            yaw_reg      <= '0;
            prev_yaw_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (cmd.commit) begin
                pitch_reg    <= out_next.pitch_deg;
                roll_reg     <= out_next.roll_deg;
                yaw_reg      <= out_next.yaw_deg;
                prev_yaw_reg <= prev_new;
            end
            valid_reg <= cmd.commit | (valid_reg & ~out_ready);
        end
        if (cmd.load) in_reg <= in_data;
        if (cmd.gyro_en) begin
            case (cmd.axis)
                imu_ca_pkg::AXIS_PITCH: pg_reg <= imu_ca_pkg::sat32(g_sum);
                imu_ca_pkg::AXIS_ROLL:  rg_reg <= imu_ca_pkg::sat32(g_sum);
                default:                yg_reg <= imu_ca_pkg::sat32(g_sum);
            endcase
        end
        if (cmd.crd_latch) begin
            if (cmd.crd_sel) ra_reg <= crd_angle;
            else             pa_reg <= crd_angle;
        end
        if (cmd.blend_en) begin
            if (cmd.axis == imu_ca_pkg::AXIS_PITCH) bp_reg <= imu_ca_pkg::sat32(b_sum);
            else                                    br_reg <= imu_ca_pkg::sat32(b_sum);
        end
        if (cmd.commit) out_reg <= out_next;
    end

    assign stat.crd_done = crd_done;
    assign stat.out_hold = valid_reg & ~out_ready;
    assign out_data      = out_reg;
    assign out_valid     = valid_reg;
endmodule
`default_nettype wire

// ----- src/imu_ca_ctrl.sv -----
`default_nettype none
module imu_ca_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  imu_ca_pkg::imu_ca_stat_t stat,
    output imu_ca_pkg::imu_ca_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GYRO   = 3'd1;
    localparam logic [2:0] S_CRD_P  = 3'd2;
    localparam logic [2:0] S_WAIT_P = 3'd3;
    localparam logic [2:0] S_CRD_R  = 3'd4;
    localparam logic [2:0] S_WAIT_R = 3'd5;
    localparam logic [2:0] S_BLEND  = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    // sequence one beat through gyro, two atan2 runs, blend, commit
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = cnt_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_GYRO;
                end
            end
            S_GYRO: begin
                cmd.gyro_en = 1'b1;
                if (cnt_reg == imu_ca_pkg::AXIS_YAW) begin
                    state_next = S_CRD_P;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CRD_P: begin
                cmd.crd_start = 1'b1;
                state_next    = S_WAIT_P;
            end
            S_WAIT_P: begin
                if (stat.crd_done) begin
                    cmd.crd_latch = 1'b1;
                    state_next    = S_CRD_R;
                end
            end
            S_CRD_R: begin
                cmd.crd_start = 1'b1;
                cmd.crd_sel   = 1'b1;
                state_next    = S_WAIT_R;
            end
            S_WAIT_R: begin
                cmd.crd_sel = 1'b1;
                if (stat.crd_done) begin
                    cmd.crd_latch = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_BLEND;
                end
            end
            S_BLEND: begin
                cmd.blend_en = 1'b1;
                if (cnt_reg == imu_ca_pkg::AXIS_ROLL) begin
                    state_next = S_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_COMMIT: begin
                // hold until the output register is free
                if (!stat.out_hold) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/imu_complementary_attitude.sv -----
// Attitude estimator: one six-axis IMU sample in, updated pitch/roll/yaw out.
// Input channel s_valid/s_ready/s_data carries one sample per beat; output
// channel m_valid/m_ready/m_data returns one beat of angles (Q16.16 degrees)
// per input beat, in order.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 mode, 1 rate_gain, 2 yaw_rate_gain, 3 gyro_weight, 4 yaw_deadband);
// write only while no sample is in flight.
// The two atan2 evaluations run back to back on one shared CORDIC unit, one
// micro-rotation a cycle. One sample is in flight at a time and s_ready rises
// in the cycle after the commit, so a new beat is not taken before the last
// one is committed.
// The result sits in an output register: s_ready returns while it waits, and
// the next sample is worked on; its commit waits while m_valid is stalled.
// Reset (aresetn low, synchronous) clears the angles, drops m_valid and
// loads the register defaults.
`default_nettype none
module imu_complementary_attitude #(
    parameter int CORDIC_STEPS = imu_ca_pkg::CORDIC_STEPS_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  imu_ca_pkg::imu_ca_in_t  s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output imu_ca_pkg::imu_ca_out_t m_data,
    input  wire                     cfg_wr_en,
    input  wire  [2:0]              cfg_index,
    input  wire  [31:0]             cfg_wdata
);
    imu_ca_pkg::imu_ca_cmd_t  cmd;
    imu_ca_pkg::imu_ca_stat_t stat;

    imu_ca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imu_ca_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_data),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import imu_ca_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam logic [1:0] MODE_HOLD  = 2'd3;
    localparam int SETTLE_CYCLES = 2 * CORDIC_STEPS_DEF + 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int RAND_PER_SET  = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    imu_ca_in_t  s_data;
    logic        m_valid;
    logic        m_ready;
    imu_ca_out_t m_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    imu_complementary_attitude uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow registers and angle state of the estimator
    logic [1:0]  sh_mode;
    logic [31:0] sh_rate_gain;
    logic [31:0] sh_yaw_gain;
    logic [16:0] sh_weight;
    logic [30:0] sh_deadband;
    int          est_pitch, est_roll, est_yaw, est_prev_yaw;

    imu_ca_out_t angles_due[$];
    int  n_beats_in, n_beats_out, n_errors, idle_cycles;
    bit  quiet;

    // atan(2^-i) in Q16.16 degrees
    int arctan_q16 [32] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                            29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    typedef struct {
        logic [1:0]  mode;
        imu_ca_in_t  sample;
        bit          known;
        imu_ca_out_t angles;
    } vector_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] rate_gain;
        logic [31:0] yaw_gain;
        logic [16:0] weight;
        logic [30:0] deadband;
    } setting_t;

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint rate_step(int g, logic [31:0] gain);
        longint p;
        p = longint'(g) * longint'({32'h0, gain});
        return (p + 32768) >>> 16;
    endfunction

    function automatic int tilt_deg(int yin, int xin);
        longint x, y, z, nx, ny;
        z = 0;
        if (yin == 0 && xin == 0) return 0;
        x = longint'(xin) * 65536;
        y = longint'(yin) * 65536;
        // pre-rotate into the right half plane
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; z = 90 * 65536;
            end else begin
                nx = -y; ny = x; z = -90 * 65536;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_q16[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_q16[i];
            end
            x = nx; y = ny;
        end
        return clamp32(z);
    endfunction

    function automatic int mix(int g, int a, longint w);
        longint s;
        s = w * g + (65536 - w) * a;
        return clamp32((s + 32768) >>> 16);
    endfunction

    // advance the estimator by one sample and return the new angles
    function automatic imu_ca_out_t next_attitude(imu_ca_in_t d);
        imu_ca_out_t r;
        int pg, rg, yg, pa, ra;
        longint yaw_gap, w;
        case (sh_mode)
            MODE_GYRO: begin
                est_pitch = clamp32(longint'(est_pitch) - rate_step(d.gyro_y, sh_rate_gain));
                est_roll  = clamp32(longint'(est_roll) + rate_step(d.gyro_x, sh_rate_gain));
                est_yaw   = clamp32(longint'(est_yaw) + rate_step(d.gyro_z, sh_rate_gain));
            end
            MODE_ACCEL: begin
                est_pitch = tilt_deg(d.acc_x, d.acc_z);
                est_roll  = tilt_deg(d.acc_y, d.acc_z);
                est_yaw   = 0;
            end
            MODE_FUSE: begin
                w  = (sh_weight > WEIGHT_ONE) ? 65536 : longint'(sh_weight);
                pg = clamp32(longint'(est_pitch) - rate_step(d.gyro_y, sh_rate_gain));
                rg = clamp32(longint'(est_roll) + rate_step(d.gyro_x, sh_rate_gain));
                yg = clamp32(longint'(est_yaw) + rate_step(d.gyro_z, sh_yaw_gain));
                pa = tilt_deg(d.acc_x, d.acc_z);
                ra = tilt_deg(d.acc_y, d.acc_z);
                yaw_gap = longint'(yg) - longint'(est_prev_yaw);
                if (yaw_gap < 0) yaw_gap = -yaw_gap;
                est_pitch = mix(pg, pa, w);
                est_roll  = mix(rg, ra, w);
                est_yaw   = (yaw_gap > longint'(sh_deadband)) ? yg : est_prev_yaw;
                est_prev_yaw = est_yaw;
            end
            default: ;
        endcase
        r.pitch_deg = est_pitch;
        r.roll_deg  = est_roll;
        r.yaw_deg   = est_yaw;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom);
        if (r < 8) return 16'($signed($urandom_range(0, 4000)) - 2000);
        if (r == 8) return 16'h8000;
        return 16'h7FFF;
    endfunction

    // drive one beat, hold until taken, then log the expected angles
    task automatic send_sample(imu_ca_in_t d, bit known, imu_ca_out_t fixed);
        imu_ca_out_t due;
        int gap;
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        due = next_attitude(d);
        if (known) due = fixed;
        angles_due.push_back(due);
        n_beats_in++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one write strobe; cfg_wr_en is low again before the next write
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MODE:          sh_mode      = val[1:0];
            REG_RATE_GAIN:     sh_rate_gain = val;
            REG_YAW_RATE_GAIN: sh_yaw_gain  = val;
            REG_GYRO_WEIGHT:   sh_weight    = val[16:0];
            REG_YAW_DEADBAND:  sh_deadband  = val[30:0];
            default: ;
        endcase
    endtask

    // result side: random stalls, compare each beat with the oldest expectation
    int stall_left;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) < 2) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_beats_out++;
            if (angles_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat %0p", m_data);
            end else begin
                imu_ca_out_t want;
                want = angles_due.pop_front();
                if (m_data.pitch_deg !== want.pitch_deg || m_data.roll_deg !== want.roll_deg
                        || m_data.yaw_deg !== want.yaw_deg) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("beat %0d: expected p=%0d r=%0d y=%0d got p=%0d r=%0d y=%0d",
                                 n_beats_out, want.pitch_deg, want.roll_deg, want.yaw_deg,
                                 m_data.pitch_deg, m_data.roll_deg, m_data.yaw_deg);
                end
            end
        end
    end

    // watchdog: end the run if no beat moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    vector_t  vectors [$];
    setting_t settings [$];

    function automatic imu_ca_in_t make_sample(int ax, int ay, int az,
                                               int gx, int gy, int gz);
        imu_ca_in_t d;
        d.acc_x = 16'(ax); d.acc_y = 16'(ay); d.acc_z = 16'(az);
        d.gyro_x = 16'(gx); d.gyro_y = 16'(gy); d.gyro_z = 16'(gz);
        return d;
    endfunction

    function automatic void add_vec(logic [1:0] m, imu_ca_in_t d);
        vector_t v;
        v.mode = m; v.sample = d; v.known = 0; v.angles = '0;
        vectors.push_back(v);
    endfunction

    initial begin
        imu_ca_in_t d;
        vector_t v;
        setting_t cfg;
        aresetn = 1'b0; s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        stall_left = 0; quiet = 0; idle_cycles = 0;
        n_beats_in = 0; n_beats_out = 0; n_errors = 0;
        sh_mode = MODE_RST; sh_rate_gain = RATE_GAIN_RST; sh_yaw_gain = YAW_RATE_GAIN_RST;
        sh_weight = GYRO_WEIGHT_RST; sh_deadband = YAW_DEADBAND_RST;
        est_pitch = 0; est_roll = 0; est_yaw = 0; est_prev_yaw = 0;

        // directed table; the first row is the reset state seen through a still sample
        v.mode = MODE_FUSE; v.sample = '0; v.known = 1; v.angles = '0;
        vectors.push_back(v);
        add_vec(MODE_FUSE, make_sample(0, 0, 16384, 100, -100, 500));
        add_vec(MODE_FUSE, make_sample(32767, -32768, -32768, 32767, -32768, 32767));
        add_vec(MODE_ACCEL, make_sample(0, 0, 0, 5, 5, 5));
        add_vec(MODE_ACCEL, make_sample(0, 0, -32768, 0, 0, 0));
        add_vec(MODE_ACCEL, make_sample(-32768, 32767, -1, 0, 0, 0));
        add_vec(MODE_ACCEL, make_sample(32767, -32768, 32767, 0, 0, 0));
        add_vec(MODE_ACCEL, make_sample(-1, 1, 0, 0, 0, 0));
        add_vec(MODE_GYRO, make_sample(0, 0, 0, 32767, -32768, 32767));
        add_vec(MODE_GYRO, make_sample(0, 0, 0, -32768, 32767, -32768));
        add_vec(MODE_GYRO, make_sample(0, 0, 0, 0, 0, 0));
        add_vec(MODE_HOLD, make_sample(123, -456, 789, 1000, -1000, 1000));
        add_vec(MODE_FUSE, make_sample(100, 100, 16000, 0, 0, 1));
        add_vec(MODE_FUSE, make_sample(100, 100, 16000, 0, 0, 4000));
        add_vec(MODE_FUSE, make_sample(-16000, 0, 0, -20, 20, -4000));

        // register settings for the random part, extremes included
        settings.push_back('{MODE_FUSE, RATE_GAIN_RST, YAW_RATE_GAIN_RST,
                             GYRO_WEIGHT_RST, YAW_DEADBAND_RST});
        settings.push_back('{MODE_GYRO, 32'hFFFF_FFFF, 32'h0, 17'd0, 31'd0});
        settings.push_back('{MODE_GYRO, 32'h0, 32'hFFFF_FFFF, 17'd65536, 31'h7FFF_FFFF});
        settings.push_back('{MODE_ACCEL, 32'h1234_5678, 32'h0, 17'd1000, 31'd100});
        settings.push_back('{MODE_FUSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, 31'd0});
        settings.push_back('{MODE_FUSE, 32'h0010_0000, 32'h0020_0000, 17'h1FFFF, 31'h7FFF_FFFF});
        settings.push_back('{MODE_FUSE, 32'h0, 32'h0, 17'd65536, 31'd0});
        settings.push_back('{MODE_FUSE, 32'h0300_0000, 32'h0500_0000, 17'd32768, 31'd65536});
        settings.push_back('{MODE_HOLD, 32'hAAAA_5555, 32'h5555_AAAA, 17'h0AAAA, 31'h2AAA_AAAA});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (vectors[i]) begin
            if (vectors[i].mode != sh_mode) begin
                drain();
                write_reg(REG_MODE, {30'h0, vectors[i].mode});
            end
            send_sample(vectors[i].sample, vectors[i].known, vectors[i].angles);
        end

        // random part, one phase per register setting
        foreach (settings[k]) begin
            cfg = settings[k];
            drain();
            write_reg(REG_RATE_GAIN, cfg.rate_gain);
            write_reg(REG_YAW_RATE_GAIN, cfg.yaw_gain);
            write_reg(REG_GYRO_WEIGHT, {15'h0, cfg.weight});
            write_reg(REG_YAW_DEADBAND, {1'b0, cfg.deadband});
            write_reg(REG_UNUSED, $urandom);
            write_reg(REG_MODE, {30'h0, cfg.mode});
            quiet = (k % 3 == 2);
            repeat (RAND_PER_SET) begin
                d.acc_x = rand_field(); d.acc_y = rand_field(); d.acc_z = rand_field();
                d.gyro_x = rand_field(); d.gyro_y = rand_field(); d.gyro_z = rand_field();
                send_sample(d, 0, '0);
            end
        end
        quiet = 0;
        drain();

        $display("Sent %0d samples over %0d register settings, %0d result beats checked.",
                 n_beats_in, settings.size(), n_beats_out);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatching beats.", n_errors);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
